[rtl/core/sorted_snake_matrix_fill_defines.svh]
// assertion macros for the sorted snake matrix fill block
// expects clk and arst_n in the scope of each use
`ifndef SORTED_SNAKE_MATRIX_FILL_DEFINES_SVH
`define SORTED_SNAKE_MATRIX_FILL_DEFINES_SVH

`ifndef SYNTHESIS
`define SSMF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SSMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSMF_ASSERT_SAME(label, ante, cons, msg)
`define SSMF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/ssmf_pkg.sv]
// shared types and constants of the sorted snake matrix fill block
// no dependencies
`timescale 1ns / 1ps

package ssmf_pkg;

	localparam int VAL_W  = 16;
	localparam int POS_W  = 3;
	localparam int SIDE_W = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;
	localparam logic              REG_SIDE   = 1'b0;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [SIDE_W-1:0]       side_t;

	typedef struct packed {
		logic insert;
		logic clear;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic load_done;
		logic drain_last;
	} stat_t;

endpackage

[rtl/core/ssmf_ctrl.sv]
// controller of the sorted snake matrix fill block: load and drain sequencing
// depends on ssmf_pkg
`timescale 1ns / 1ps

module ssmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          cfg_wr,
	input  ssmf_pkg::stat_t stat,
	output ssmf_pkg::cmd_t  cmd
);
	import ssmf_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.insert = in_valid && (state_q == ST_LOAD);
		cmd.clear  = cfg_wr;
		cmd.pop    = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (cmd.insert && stat.load_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.pop && stat.drain_last) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

[rtl/core/ssmf_dpath.sv]
// datapath of the sorted snake matrix fill block: insertion chain, counters,
// snake position and output register; depends on ssmf_pkg
`timescale 1ns / 1ps

module ssmf_dpath #(
	parameter int MAX_SIDE = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssmf_pkg::cmd_t  cmd,
	output ssmf_pkg::stat_t stat,
	input  ssmf_pkg::side_t side,
	input  ssmf_pkg::val_t  value,
	output ssmf_pkg::val_t  value_res,
	output ssmf_pkg::pos_t  row,
	output ssmf_pkg::pos_t  col,
	output logic            last
);
	import ssmf_pkg::*;

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int CNT_W = $clog2(DEPTH + 1);

	val_t               cell_q [DEPTH];
	logic [DEPTH-1:0]   gt;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   remaining_q;
	logic [CNT_W-1:0]   total;
	logic [2*SIDE_W-1:0] prod;
	side_t              n_eff;
	side_t              nm1;
	pos_t               row_q;
	pos_t               p_q;
	pos_t               col_now;
	val_t               value_res_q;
	pos_t               row_res_q;
	pos_t               col_res_q;
	logic               last_q;

	// side saturated to 1..MAX_SIDE
	always_comb begin
		if (side == '0) begin
			n_eff = SIDE_W'(1);
		end else if (side > SIDE_W'(MAX_SIDE)) begin
			n_eff = SIDE_W'(MAX_SIDE);
		end else begin
			n_eff = side;
		end
	end

	assign prod    = {{SIDE_W{1'b0}}, n_eff} * {{SIDE_W{1'b0}}, n_eff};
	assign total   = prod[CNT_W-1:0];
	assign nm1     = n_eff - SIDE_W'(1);
	assign col_now = row_q[0] ? (nm1[POS_W-1:0] - p_q) : p_q;

	assign stat.load_done  = (CNT_W'(count_q + CNT_W'(1)) == total);
	assign stat.drain_last = (remaining_q == CNT_W'(1));

	// cells at and past the fill level, or holding a larger value, move up
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) >= count_q) || (cell_q[i] > value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (gt[0]) begin
				cell_q[0] <= value;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (gt[i]) begin
					cell_q[i] <= gt[i-1] ? cell_q[i-1] : value;
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			value_res_q <= cell_q[0];
			row_res_q   <= row_q;
			col_res_q   <= col_now;
			last_q      <= stat.drain_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			remaining_q <= '0;
			row_q       <= '0;
			p_q         <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			if (stat.load_done) begin
				count_q     <= '0;
				remaining_q <= total;
				row_q       <= '0;
				p_q         <= '0;
			end else begin
				count_q <= CNT_W'(count_q + CNT_W'(1));
			end
		end else if (cmd.pop) begin
			remaining_q <= CNT_W'(remaining_q - CNT_W'(1));
			if (p_q == nm1[POS_W-1:0]) begin
				p_q   <= '0;
				row_q <= POS_W'(row_q + POS_W'(1));
			end else begin
				p_q <= POS_W'(p_q + POS_W'(1));
			end
		end
	end

	assign value_res = value_res_q;
	assign row       = row_res_q;
	assign col       = col_res_q;
	assign last      = last_q;

endmodule

[rtl/core/sorted_snake_matrix_fill.sv]
// top level of the sorted snake matrix fill block: config register and glue
// depends on ssmf_pkg, ssmf_ctrl, ssmf_dpath and the assertion macro header
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------
// cfg      | psel penable pwrite  | paddr pwdata prdata
// in       | in_valid in_ready    | value
// out      | out_valid out_ready  | value_res row col last
//
// loading inserts each accepted item in place through the parallel insertion chain
// the n*n-th item starts a drain of n*n results, one result per cycle
// from cell 0 of the chain; in_ready is low during the drain
// output stalls hold the drain; reset leaves side 8 and an empty chain
`timescale 1ns / 1ps
`include "sorted_snake_matrix_fill_defines.svh"

module sorted_snake_matrix_fill #(
	parameter int MAX_SIDE = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssmf_pkg::ADDR_W-1:0]   paddr,
	input  logic [ssmf_pkg::DATA_W-1:0]   pwdata,
	output logic [ssmf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ssmf_pkg::val_t                value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ssmf_pkg::val_t                value_res,
	output ssmf_pkg::pos_t                row,
	output ssmf_pkg::pos_t                col,
	output logic                          last
);
	import ssmf_pkg::*;

	side_t side_q;
	logic  cfg_wr;
	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SIDE);
	assign prdata = (paddr[ADDR_W-1] == REG_SIDE) ? DATA_W'(side_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_wr) begin
			side_q <= pwdata[SIDE_W-1:0];
		end
	end

	ssmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_wr    (cfg_wr),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssmf_dpath #(
		.MAX_SIDE (MAX_SIDE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.side      (side_q),
		.value     (value),
		.value_res (value_res),
		.row       (row),
		.col       (col),
		.last      (last)
	);

	`SSMF_ASSERT_NEXT(a_full_starts_drain, cmd.insert && stat.load_done, !in_ready, "no drain after full matrix")
	`SSMF_ASSERT_SAME(a_drain_blocks_input, out_valid && !last, !in_ready, "input open during drain")
	`SSMF_ASSERT_NEXT(a_pop_gives_item, cmd.pop, out_valid, "popped item not presented")

endmodule

[sim/tb_sorted_snake_matrix_fill.sv]
`timescale 1ns / 1ps
// self-checking testbench for sorted_snake_matrix_fill: feeds square matrices item by item
// and checks every sorted, snake-placed result against an in-bench prediction
// depends on ssmf_pkg and the sorted_snake_matrix_fill rtl

module tb_sorted_snake_matrix_fill;
	import ssmf_pkg::*;

	localparam int MAX_SIDE = 8;
	localparam int REG_SPARE = 1;
	localparam logic [ADDR_W-1:0] SIDE_ADDR = ADDR_W'(4 * REG_SIDE);
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * REG_SPARE);
	localparam int SETTLE = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS = 200;

	typedef struct {
		val_t value;
		pos_t row;
		pos_t col;
		logic last;
	} placement_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	val_t              value;
	logic              out_valid;
	logic              out_ready;
	val_t              value_res;
	pos_t              row;
	pos_t              col;
	logic              last;

	sorted_snake_matrix_fill #(.MAX_SIDE(MAX_SIDE)) i_dut (.*);

	val_t        matrix_buf [MAX_SIDE*MAX_SIDE];
	int unsigned load_cnt;
	side_t       side_reg;
	placement_t  placements[$];
	val_t        pending[$];
	logic        in_fire = 1'b0;
	logic        calm;
	int          errs = 0;
	int          stall_cnt = 0;

	always #10 clk = ~clk;

	function automatic int unsigned side_used(input side_t s);
		if (s == 0)
			return 1;
		if (s > MAX_SIDE)
			return MAX_SIDE;
		return s;
	endfunction

	// store one element, and on the last one of a matrix sort and place them all
	function automatic void load_element(input val_t v);
		int unsigned n;
		int unsigned total;
		int j;
		val_t key;
		placement_t p;
		n = side_used(side_reg);
		total = n * n;
		if (load_cnt >= total)
			load_cnt = 0;
		matrix_buf[load_cnt] = v;
		load_cnt++;
		if (load_cnt < total)
			return;
		for (int i = 1; i < total; i++) begin
			key = matrix_buf[i];
			j = i;
			while (j > 0 && matrix_buf[j-1] > key) begin
				matrix_buf[j] = matrix_buf[j-1];
				j--;
			end
			matrix_buf[j] = key;
		end
		for (int k = 0; k < total; k++) begin
			p.value = matrix_buf[k];
			p.row = pos_t'(k / n);
			p.col = pos_t'(((k / n) % 2 == 1) ? (n - 1 - k % n) : (k % n));
			p.last = (k + 1 == total);
			placements.push_back(p);
		end
		load_cnt = 0;
	endfunction

	function automatic val_t rand_value();
		case ($urandom_range(0, 9))
			0: return val_t'(16'h8000);
			1: return val_t'(16'h7FFF);
			2, 3: return val_t'($urandom_range(0, 6)) - val_t'(3);
			default: return val_t'($urandom());
		endcase
	endfunction

	function automatic void note_mismatch(input string msg);
		errs++;
		if (errs <= 10)
			$display("mismatch: %s", msg);
	endfunction

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == SIDE_ADDR) begin
			side_reg = side_t'(data);
			load_cnt = 0;
		end
	endtask

	task automatic feed(input val_t items[$]);
		foreach (items[i])
			pending.push_back(items[i]);
		do
			@(posedge clk);
		while (pending.size() != 0 || in_valid || placements.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// input driver and output back-pressure
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pending.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
				in_valid <= 1'b1;
				value <= pending.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= calm || ($urandom_range(99) >= 21);
	end

	// item capture, result check and watchdog
	always @(posedge clk) begin
		placement_t e;
		logic moved;
		in_fire <= in_valid && in_ready;
		moved = psel && penable && pwrite && pready;
		if (in_valid && in_ready) begin
			load_element(value);
			moved = 1'b1;
		end
		if (out_valid && out_ready) begin
			moved = 1'b1;
			if (placements.size() == 0) begin
				note_mismatch($sformatf("unexpected result value %0d row %0d col %0d last %0b",
					value_res, row, col, last));
			end else begin
				e = placements.pop_front();
				if (e.value !== value_res || e.row !== row || e.col !== col || e.last !== last)
					note_mismatch($sformatf(
						"expected value %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
						e.value, e.row, e.col, e.last, value_res, row, col, last));
			end
		end
		if (moved) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("[sorted_snake_matrix_fill] ERROR");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		val_t batch[$];
		int fixed_sides[3];
		int s;
		int n;
		int total;
		int mats;
		int cnt;
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		value = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		side_reg = SIDE_RESET;
		load_cnt = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes on a 2x2 matrix
		write_reg(SIDE_ADDR, 2);
		batch = '{val_t'(16'h7FFF), val_t'(16'h8000), val_t'(0), val_t'(-1)};
		feed(batch);
		// side zero acts as side one
		write_reg(SIDE_ADDR, 0);
		batch = '{val_t'(16'h8000), val_t'(16'h7FFF)};
		feed(batch);
		// duplicates and extremes on 3x3
		write_reg(SIDE_ADDR, 3);
		batch = '{val_t'(5), val_t'(-5), val_t'(5), val_t'(16'h8000), val_t'(16'h7FFF),
			val_t'(0), val_t'(5), val_t'(-1), val_t'(16'h8000)};
		feed(batch);
		// write past the register list is ignored, two items stay partial
		write_reg(SPARE_ADDR, 1);
		batch = '{val_t'(7), val_t'(-7)};
		feed(batch);
		// side write mid-load drops the partial matrix
		write_reg(SIDE_ADDR, 2);
		batch = '{val_t'(100), val_t'(-100), val_t'(3), val_t'(3)};
		feed(batch);

		fixed_sides = '{15, 8, 1};
		cnt = 0;
		phase = 0;
		while (cnt < RAND_ITEMS) begin
			if (phase < 3)
				s = fixed_sides[phase];
			else if ($urandom_range(0, 9) < 7)
				s = $urandom_range(1, 4);
			else
				s = $urandom_range(0, 15);
			calm = (phase == 0);
			write_reg(SIDE_ADDR, ($urandom() & ~32'hF) | s);
			n = side_used(side_t'(s));
			total = n * n;
			mats = (total >= 36) ? 1 : $urandom_range(1, 3);
			batch = {};
			repeat (mats * total) batch.push_back(rand_value());
			if (total > 1 && $urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, total - 1)) batch.push_back(rand_value());
			cnt += batch.size();
			feed(batch);
			phase++;
		end
		calm = 1'b0;

		if (errs == 0)
			$display("[sorted_snake_matrix_fill] OK");
		else
			$display("[sorted_snake_matrix_fill] ERROR");
		$finish;
	end

endmodule
